/* rtl/prime_counter_trial_division_top_defines.svh */
// Assertion macros for the prime counter trial division block.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef PRIME_COUNTER_TRIAL_DIVISION_TOP_DEFINES_SVH
`define PRIME_COUNTER_TRIAL_DIVISION_TOP_DEFINES_SVH

// Implication checked at every edge outside reset.
`define PCTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define PCTD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* rtl/pctd_pkg.sv */
// Shared types for the prime counter trial division block.
// No dependencies; used by pctd_rem and the top level.
`default_nettype none

package pctd_pkg;

  // Command from the sequencer to the remainder unit.
  typedef struct packed {
    logic start;
  } rem_ctrl_t;

  // Status from the remainder unit back to the sequencer.
  typedef struct packed {
    logic done;   // one-cycle pulse, remainder ready
    logic zero;   // remainder is zero, valid with done
  } rem_stat_t;

endpackage

`default_nettype wire

/* rtl/pctd_rem.sv */
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on pctd_pkg for the control and status structs.
`default_nettype none

module pctd_rem #(
  parameter int DATA_WIDTH = 32,
  parameter int DIV_WIDTH  = 17
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire pctd_pkg::rem_ctrl_t     ctrl,
  input  wire logic [DATA_WIDTH-1:0]   dividend,
  input  wire logic [DIV_WIDTH-1:0]    divisor,
  output pctd_pkg::rem_stat_t          stat
);
  import pctd_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] sh;
  logic [DIV_WIDTH-1:0]  r;
  logic [CNT_W-1:0]      cnt;
  logic                  done;

  logic [DIV_WIDTH:0]    trial;
  logic [DIV_WIDTH:0]    diff;
  logic                  ge;

  // Bring down the next dividend bit and subtract if it fits.
  assign trial = {r, sh[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (ctrl.start) begin
      cnt  <= CNT_W'(DATA_WIDTH);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CNT_W'(1);
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sh <= dividend;
      r  <= '0;
    end else if (cnt != '0) begin
      sh <= {sh[DATA_WIDTH-2:0], 1'b0};
      r  <= ge ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
    end
  end

  assign stat.done = done;
  assign stat.zero = (r == '0);

endmodule

`default_nettype wire

/* rtl/prime_counter_trial_division_top.sv */
// Top level of the prime counter: trial division sequencer and set counter.
// Depends on pctd_pkg, pctd_rem and prime_counter_trial_division_top_defines.svh.
//
// Each input beat carries a signed number (s_tdata) and an end-of-set mark
// (s_tlast); each yields one output beat with the prime flag (m_tuser), the
// running prime count of the set, saturating (m_tdata), and the echoed mark
// (m_tlast). The count clears after a beat with the mark set. One number is
// worked on at a time. Negative values, 0, 1, 2 and even values go straight
// to the done state after acceptance, without division. Odd values try odd
// divisors from 3 upward while the divisor squared is at most the value; each
// divisor takes a bound check in the check state and then a pass of the
// bit-serial remainder unit, which takes one dividend bit per cycle. A 32-bit
// prime near the top of the range tries about 23170 divisors. A new number is
// taken while the previous result still waits on the output.
`default_nettype none

`include "prime_counter_trial_division_top_defines.svh"

module prime_counter_trial_division_top #(
  parameter int DATA_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]       s_tdata,   // [DATA_WIDTH-1:0] value
  input  wire logic                                  s_tlast,   // last_item
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [((COUNT_WIDTH+7)/8)*8-1:0]           m_tdata,   // [COUNT_WIDTH-1:0] prime_count
  output logic                                       m_tuser,   // prime_flag
  output logic                                       m_tlast    // set_done
);
  import pctd_pkg::*;

  localparam int MT_W  = ((COUNT_WIDTH + 7) / 8) * 8;
  localparam int DV_W  = (DATA_WIDTH + 1) / 2 + 1;
  localparam int SQ_W  = DATA_WIDTH + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]             state;
  logic [DATA_WIDTH-1:0]  value;
  logic                   last;
  logic                   prime;
  logic [DV_W-1:0]        divisor;
  logic [SQ_W-1:0]        square;
  logic [COUNT_WIDTH-1:0] running_count;
  logic [COUNT_WIDTH-1:0] out_count;

  logic [DATA_WIDTH-1:0]  in_value;
  logic                   in_accept;
  logic                   in_trivial_no;
  logic                   in_is_two;
  logic                   out_free;
  logic [COUNT_WIDTH-1:0] count_next;

  rem_ctrl_t              rem_ctrl;
  rem_stat_t              rem_stat;

  assign in_value      = s_tdata[DATA_WIDTH-1:0];
  assign s_tready      = (state == ST_IDLE);
  assign in_accept     = s_tvalid && s_tready;
  // Negative, zero, one or even values settle without division; two alone of them is prime.
  assign in_is_two     = (in_value == DATA_WIDTH'(2));
  assign in_trivial_no = in_value[DATA_WIDTH-1] || (in_value[DATA_WIDTH-1:1] == '0) ||
                         (!in_value[0] && !in_is_two);
  assign out_free      = !m_tvalid || m_tready;
  assign count_next    = (prime && (running_count != '1)) ?
                         running_count + COUNT_WIDTH'(1) : running_count;

  assign rem_ctrl.start = (state == ST_CHECK) && (square <= {1'b0, value});

  pctd_rem #(
    .DATA_WIDTH (DATA_WIDTH),
    .DIV_WIDTH  (DV_W)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (rem_ctrl),
    .dividend (value),
    .divisor  (divisor),
    .stat     (rem_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      running_count <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= (in_trivial_no || in_is_two) ? ST_DONE : ST_CHECK;
          end
        end
        ST_CHECK: begin
          // Divisor squared past the value: no factor found.
          state <= rem_ctrl.start ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (rem_stat.done) begin
            state <= rem_stat.zero ? ST_DONE : ST_CHECK;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            running_count <= last ? '0 : count_next;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      value   <= in_value;
      last    <= s_tlast;
      prime   <= in_is_two || !in_trivial_no;
      divisor <= DV_W'(3);
      square  <= SQ_W'(9);
    end else if (state == ST_DIV && rem_stat.done) begin
      if (rem_stat.zero) begin
        prime <= 1'b0;
      end else begin
        // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4.
        divisor <= divisor + DV_W'(2);
        square  <= square + SQ_W'({divisor, 2'b00}) + SQ_W'(3'd4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_count <= count_next;
      m_tuser   <= prime;
      m_tlast   <= last;
    end
  end

  assign m_tdata = MT_W'(out_count);

  `PCTD_ASSERT_IMP(a_rem_done_in_div, rem_stat.done, state == ST_DIV,
                   "remainder finished outside the divide state")
  `PCTD_ASSERT_IMP(a_out_from_done, $rose(m_tvalid), $past(state) == ST_DONE,
                   "output beat raised without a finished test")
  `PCTD_ASSERT_NEVER(a_prime_count_zero, m_tvalid && m_tuser && (out_count == '0),
                     "prime beat reports a zero count")

endmodule

`default_nettype wire
